[sv/rpa_pkg.sv]
// Shared constants and codes for the refcounted page allocator.
package rpa_pkg;

    // Default geometry and register reset values
    localparam int unsigned        RPA_PAGE_COUNT = 32768;
    localparam int unsigned        RPA_PAGE_BYTES = 4096;
    localparam logic [47:0]        RPA_RAM_BASE   = 48'h0000_8000_0000;
    localparam logic [47:0]        RPA_START_RST  = 48'h0000_8000_0000;
    localparam logic [47:0]        RPA_END_RST    = 48'h0000_8800_0000;

    // Fixed sizes used by the allocation modes
    localparam logic [31:0]        SMALL_PAGE     = 32'd4096;
    localparam logic [4:0]         SMALL_LOG      = 5'd12;
    localparam logic [48:0]        START_ALIGN    = 49'd16;
    localparam logic [4:0]         ALIGN_LOG_MAX  = 5'd16;
    localparam logic [15:0]        COUNT_MAX      = 16'hFFFF;

    // Bump pointer after reset: start rounded up to START_ALIGN
    localparam logic [47:0]        RPA_BUMP_RST   =
        48'((49'(RPA_START_RST) + START_ALIGN - 49'd1) & ~(START_ALIGN - 49'd1));

    // Mode codes on the input port
    localparam logic [2:0] MODE_BYTES  = 3'd0;
    localparam logic [2:0] MODE_PAGE   = 3'd1;
    localparam logic [2:0] MODE_ADDREF = 3'd2;
    localparam logic [2:0] MODE_FREE   = 3'd3;
    localparam logic [2:0] MODE_QUERY  = 3'd4;

    // Operation codes carried from the front end to the back end
    localparam logic [2:0] OP_BYTES  = 3'd0;
    localparam logic [2:0] OP_PAGE   = 3'd1;
    localparam logic [2:0] OP_ADDREF = 3'd2;
    localparam logic [2:0] OP_FREE   = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;
    localparam logic [2:0] OP_NOP    = 3'd5;

    // Configuration register indexes
    localparam logic REG_START = 1'b0;
    localparam logic REG_END   = 1'b1;

endpackage

[sv/refcounted_page_allocator_unit.sv]
// Top level of the refcounted page allocator.
//
//  channel   direction  handshake                      payload
//  command   in         start high, busy low           i_mode, i_page_address,
//                                                      i_byte_count, i_align_log2
//  result    out        o_result_valid (one cycle)     o_success, o_result_address,
//                                                      o_ref_count, o_used_pages,
//                                                      o_available_pages
//  config    in         i_cfg_valid and o_cfg_ready    i_cfg_index, i_cfg_data
//
// Flow: a taken word waits in the front register, then in the two-entry queue; the
//   back end pops it only while idle. Reference, free and query words read the
//   refcount table and reference and free words write it (no access when the address
//   is ignored or the mode is undefined); a page taken from the free stack reads the
//   stack, then reads and writes the table; a bump allocation reads and, at a count
//   of zero, writes the table for each RAM page covered, then reads the page returned.
// Reset: synchronous, active low. After reset the refcount table is cleared one
//   entry a cycle, with busy held high.
// Stalls: busy rises when the two-entry queue and the front register are full.
//   The receiver cannot stall; each result is shown for exactly one cycle.
//   Config ready is high only while no word is in flight and start is low.
module refcounted_page_allocator_unit
    import rpa_pkg::*;
#(
    parameter int unsigned PAGE_COUNT = RPA_PAGE_COUNT,
    parameter int unsigned PAGE_BYTES = RPA_PAGE_BYTES,
    parameter logic [47:0] RAM_BASE   = RPA_RAM_BASE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [47:0] i_page_address,
    input  logic [31:0] i_byte_count,
    input  logic [4:0]  i_align_log2,
    output logic        o_result_valid,
    output logic        o_success,
    output logic [47:0] o_result_address,
    output logic [15:0] o_ref_count,
    output logic [15:0] o_used_pages,
    output logic [31:0] o_available_pages,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    // Job word: op, page check, slot, byte count, alignment
    localparam int unsigned JOB_W = 3 + 1 + $clog2(PAGE_COUNT) + 32 + 5;

    logic             w_front_stall;
    logic             w_front_held;
    logic             w_clearing;
    logic             w_back_idle;
    logic             w_cfg_we;
    logic             w_take;
    logic             w_push;
    logic [JOB_W-1:0] w_push_job;
    logic             w_full;
    logic             w_pop;
    logic [JOB_W-1:0] w_pop_job;
    logic             w_empty;

    // Hold off new words during the table clear and when the queue backs up
    assign busy        = w_front_stall || w_clearing;
    assign w_take      = start && !busy;
    // Accept register writes only with nothing in flight and no word arriving
    assign o_cfg_ready = w_back_idle && w_empty && !w_front_held && !start;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    rpa_front #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_BYTES (PAGE_BYTES),
        .RAM_BASE   (RAM_BASE),
        .JOB_W      (JOB_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (w_take),
        .i_mode         (i_mode),
        .i_page_address (i_page_address),
        .i_byte_count   (i_byte_count),
        .i_align_log2   (i_align_log2),
        .o_stall        (w_front_stall),
        .o_held         (w_front_held),
        .o_push         (w_push),
        .o_job          (w_push_job),
        .i_full         (w_full)
    );

    rpa_fifo #(
        .W (JOB_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_job),
        .o_empty (w_empty)
    );

    rpa_back #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_BYTES (PAGE_BYTES),
        .RAM_BASE   (RAM_BASE),
        .JOB_W      (JOB_W)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job             (w_pop_job),
        .i_empty           (w_empty),
        .o_pop             (w_pop),
        .i_cfg_valid       (w_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_clearing        (w_clearing),
        .o_idle            (w_back_idle),
        .o_res_valid       (o_result_valid),
        .o_success         (o_success),
        .o_result_address  (o_result_address),
        .o_ref_count       (o_ref_count),
        .o_used_pages      (o_used_pages),
        .o_available_pages (o_available_pages)
    );

endmodule

[sv/rpa_fifo.sv]
// Two-entry job queue between the front end and the back end.
module rpa_fifo
    import rpa_pkg::*;
#(
    parameter int unsigned W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    logic [W-1:0] r_buf [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         n_wp;
    logic         n_rp;
    logic [1:0]   n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_buf[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push && !o_full) begin
            n_wp = ~r_wp;
        end
        if (i_pop && !o_empty) begin
            n_rp = ~r_rp;
        end
        if ((i_push && !o_full) && !(i_pop && !o_empty)) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!(i_push && !o_full) && (i_pop && !o_empty)) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_buf[r_wp] <= i_data;
        end
    end

endmodule

[sv/rpa_front.sv]
// Front end: accept a command word, decode the mode and check the page address.
module rpa_front
    import rpa_pkg::*;
#(
    parameter int unsigned PAGE_COUNT = RPA_PAGE_COUNT,
    parameter int unsigned PAGE_BYTES = RPA_PAGE_BYTES,
    parameter logic [47:0] RAM_BASE   = RPA_RAM_BASE,
    parameter int unsigned JOB_W      = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [2:0]       i_mode,
    input  logic [47:0]      i_page_address,
    input  logic [31:0]      i_byte_count,
    input  logic [4:0]       i_align_log2,
    output logic             o_stall,
    output logic             o_held,
    output logic             o_push,
    output logic [JOB_W-1:0] o_job,
    input  logic             i_full
);

    localparam int unsigned SW  = $clog2(PAGE_COUNT);
    localparam int unsigned LOG = $clog2(PAGE_BYTES);
    localparam logic [63:0] LIM   = 64'(RAM_BASE) + 64'(PAGE_COUNT) * 64'(PAGE_BYTES);
    localparam logic [63:0] CEILQ = (64'(RAM_BASE) + 64'(PAGE_BYTES) - 64'd1) >> LOG;

    typedef struct packed {
        logic [2:0]    op;
        logic          page_ok;
        logic [SW-1:0] slot;
        logic [31:0]   bytes;
        logic [4:0]    lg;
    } t_job;

    t_job        r_job;
    logic        r_vld;
    t_job        n_job;
    logic        n_vld;
    logic        w_slot_ok;
    logic [47:0] w_pidx;

    assign w_pidx    = i_page_address >> LOG;
    assign w_slot_ok = (i_page_address[LOG-1:0] == '0) && (i_page_address >= RAM_BASE)
                       && (64'(i_page_address) < LIM);

    assign o_stall = r_vld && i_full;
    assign o_held  = r_vld;
    assign o_push  = r_vld && !i_full;
    assign o_job   = JOB_W'(r_job);

    always_comb begin
        n_job.slot  = SW'(w_pidx - CEILQ[47:0]);
        n_job.bytes = i_byte_count;
        n_job.lg    = (i_align_log2 > ALIGN_LOG_MAX) ? ALIGN_LOG_MAX : i_align_log2;
        n_job.page_ok = 1'b0;
        unique case (i_mode)
            MODE_BYTES:  n_job.op = OP_BYTES;
            MODE_PAGE:   n_job.op = OP_PAGE;
            MODE_ADDREF: begin
                n_job.op      = OP_ADDREF;
                n_job.page_ok = w_slot_ok;
            end
            MODE_FREE: begin
                n_job.op      = OP_FREE;
                n_job.page_ok = w_slot_ok && (i_page_address != 48'd0);
            end
            MODE_QUERY: begin
                n_job.op      = OP_QUERY;
                n_job.page_ok = w_slot_ok;
            end
            default:     n_job.op = OP_NOP;
        endcase
        n_vld = r_vld;
        if (i_take) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_job <= n_job;
        end
    end

endmodule

[sv/rpa_back.sv]
// Back end: refcount table, free page stack, bump pointer and result words.
module rpa_back
    import rpa_pkg::*;
#(
    parameter int unsigned PAGE_COUNT = RPA_PAGE_COUNT,
    parameter int unsigned PAGE_BYTES = RPA_PAGE_BYTES,
    parameter logic [47:0] RAM_BASE   = RPA_RAM_BASE,
    parameter int unsigned JOB_W      = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [JOB_W-1:0] i_job,
    input  logic             i_empty,
    output logic             o_pop,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_index,
    input  logic [47:0]      i_cfg_data,
    output logic             o_clearing,
    output logic             o_idle,
    output logic             o_res_valid,
    output logic             o_success,
    output logic [47:0]      o_result_address,
    output logic [15:0]      o_ref_count,
    output logic [15:0]      o_used_pages,
    output logic [31:0]      o_available_pages
);

    localparam int unsigned SW  = $clog2(PAGE_COUNT);
    localparam int unsigned SW1 = $clog2(PAGE_COUNT + 1);
    localparam int unsigned LOG = $clog2(PAGE_BYTES);
    localparam int unsigned MW  = 50 - LOG;
    localparam int unsigned SPW = 48 - LOG;
    localparam logic [63:0] LIM   = 64'(RAM_BASE) + 64'(PAGE_COUNT) * 64'(PAGE_BYTES);
    localparam logic [63:0] CEILQ = (64'(RAM_BASE) + 64'(PAGE_BYTES) - 64'd1) >> LOG;
    localparam logic [48:0] PMASK = 49'(PAGE_BYTES) - 49'd1;
    localparam logic        BASE_ALIGNED = ((64'(RAM_BASE) & 64'(PMASK)) == 64'd0);

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_PRD  = 5'd2;
    localparam logic [4:0] S_PWR  = 5'd3;
    localparam logic [4:0] S_MOD  = 5'd4;
    localparam logic [4:0] S_B1   = 5'd5;
    localparam logic [4:0] S_B2   = 5'd6;
    localparam logic [4:0] S_B3   = 5'd7;
    localparam logic [4:0] S_B4   = 5'd8;
    localparam logic [4:0] S_CRD  = 5'd9;
    localparam logic [4:0] S_CWR  = 5'd10;
    localparam logic [4:0] S_CNT  = 5'd11;
    localparam logic [4:0] S_FIN  = 5'd12;
    localparam logic [4:0] S_OUT  = 5'd13;

    typedef struct packed {
        logic [2:0]    op;
        logic          page_ok;
        logic [SW-1:0] slot;
        logic [31:0]   bytes;
        logic [4:0]    lg;
    } t_job;

    // Memories
    logic [15:0]   r_rc_mem [PAGE_COUNT];
    logic [SW-1:0] r_st_mem [PAGE_COUNT];
    logic [15:0]   r_rc_q;
    logic [SW-1:0] r_st_q;

    logic          w_rc_re, w_rc_we, w_st_re, w_st_we;
    logic [SW-1:0] w_rc_raddr, w_rc_waddr, w_st_raddr, w_st_waddr, w_st_wdata;
    logic [15:0]   w_rc_wdata;

    // Control and datapath registers
    logic [4:0]     r_state, n_state;
    t_job           r_job, n_job, w_job;
    logic [SW1-1:0] r_s, n_s, r_hi, n_hi, r_top, n_top;
    logic [15:0]    r_owned, n_owned, w_own_inc;
    logic [47:0]    r_bump, n_bump, r_start, n_start, r_end, n_end;
    logic [4:0]     r_lg, n_lg;
    logic [31:0]    r_bytes, n_bytes;
    logic [48:0]    r_cur, n_cur, w_amask, w_pcur;
    logic [49:0]    r_next, n_next;
    logic [MW-1:0]  r_lo_m, n_lo_m, r_hi_m, n_hi_m;
    logic           r_cur_ok, n_cur_ok;
    logic [SW-1:0]  r_cur_slot, n_cur_slot;
    logic           r_ok, n_ok;
    logic [47:0]    r_addr, n_addr;
    logic [15:0]    r_cnt, n_cnt;
    logic [SPW-1:0] r_span, n_span;
    logic [48:0]    w_sum;
    logic           r_o_vld;
    logic           r_o_ok;
    logic [47:0]    r_o_addr;
    logic [15:0]    r_o_cnt, r_o_used;
    logic [31:0]    r_o_avail;

    function automatic logic [SW1-1:0] f_clip(input logic [MW-1:0] m);
        logic [63:0] v;
        v = 64'(m);
        if (v <= CEILQ) begin
            return '0;
        end else if (v >= CEILQ + 64'(PAGE_COUNT)) begin
            return SW1'(PAGE_COUNT);
        end else begin
            return SW1'(v - CEILQ);
        end
    endfunction

    assign w_job      = t_job'(i_job);
    assign w_own_inc  = (r_owned != COUNT_MAX) ? r_owned + 16'd1 : r_owned;
    assign w_amask    = (49'd1 << r_lg) - 49'd1;
    assign w_pcur     = ({1'b0, r_bump} + PMASK) & ~PMASK;
    assign w_sum      = 49'(r_span) + 49'(r_top);
    assign o_clearing = (r_state == S_CLR);
    assign o_idle     = (r_state == S_IDLE) || (r_state == S_CLR);

    always_comb begin
        n_state = r_state;   n_job = r_job;     n_s = r_s;         n_hi = r_hi;
        n_top = r_top;       n_owned = r_owned; n_bump = r_bump;   n_start = r_start;
        n_end = r_end;       n_lg = r_lg;       n_bytes = r_bytes; n_cur = r_cur;
        n_next = r_next;     n_lo_m = r_lo_m;   n_hi_m = r_hi_m;   n_cur_ok = r_cur_ok;
        n_cur_slot = r_cur_slot; n_ok = r_ok;   n_addr = r_addr;   n_cnt = r_cnt;
        n_span = r_span;
        o_pop = 1'b0;
        w_rc_re = 1'b0; w_rc_we = 1'b0; w_st_re = 1'b0; w_st_we = 1'b0;
        w_rc_raddr = r_s[SW-1:0]; w_rc_waddr = r_s[SW-1:0]; w_rc_wdata = 16'd0;
        w_st_raddr = SW'(r_top - SW1'(1)); w_st_waddr = r_top[SW-1:0];
        w_st_wdata = r_s[SW-1:0];

        unique case (r_state)
            S_CLR: begin
                w_rc_we = 1'b1;
                if (r_s == SW1'(PAGE_COUNT - 1)) begin
                    n_s     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_s = r_s + SW1'(1);
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_job = w_job;
                    n_ok  = 1'b0;
                    n_addr = 48'd0;
                    n_cnt = 16'd0;
                    unique case (w_job.op)
                        OP_BYTES: begin
                            n_lg    = w_job.lg;
                            n_bytes = w_job.bytes;
                            n_state = S_B1;
                        end
                        OP_PAGE: begin
                            if (r_top != '0) begin
                                w_st_re = 1'b1;
                                n_top   = r_top - SW1'(1);
                                n_state = S_PRD;
                            end else begin
                                n_lg    = SMALL_LOG;
                                n_bytes = SMALL_PAGE;
                                n_state = S_B1;
                            end
                        end
                        OP_ADDREF, OP_FREE, OP_QUERY: begin
                            if (w_job.page_ok) begin
                                w_rc_re    = 1'b1;
                                w_rc_raddr = w_job.slot;
                                n_s        = SW1'(w_job.slot);
                                n_state    = S_MOD;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_PRD: begin
                w_rc_re    = 1'b1;
                w_rc_raddr = r_st_q;
                n_s        = SW1'(r_st_q);
                n_state    = S_PWR;
            end
            S_PWR: begin
                w_rc_we    = 1'b1;
                w_rc_wdata = 16'd1;
                if (r_rc_q == 16'd0) begin
                    n_owned = w_own_inc;
                end
                n_ok    = 1'b1;
                n_addr  = RAM_BASE + (48'(r_s[SW-1:0]) << LOG);
                n_cnt   = BASE_ALIGNED ? 16'd1 : 16'd0;
                n_state = S_FIN;
            end
            S_MOD: begin
                n_ok = 1'b1;
                unique case (r_job.op)
                    OP_ADDREF: begin
                        w_rc_we = 1'b1;
                        if (r_rc_q == 16'd0) begin
                            w_rc_wdata = 16'd1;
                            n_owned    = w_own_inc;
                        end else if (r_rc_q != COUNT_MAX) begin
                            w_rc_wdata = r_rc_q + 16'd1;
                        end else begin
                            w_rc_wdata = r_rc_q;
                        end
                        n_cnt = w_rc_wdata;
                    end
                    OP_FREE: begin
                        if (r_rc_q != 16'd0) begin
                            w_rc_we    = 1'b1;
                            w_rc_wdata = r_rc_q - 16'd1;
                            if (r_rc_q == 16'd1) begin
                                if (r_owned != 16'd0) begin
                                    n_owned = r_owned - 16'd1;
                                end
                                if (r_top < SW1'(PAGE_COUNT)) begin
                                    w_st_we = 1'b1;
                                    n_top   = r_top + SW1'(1);
                                end
                            end
                        end
                        n_cnt = w_rc_wdata;
                    end
                    default: n_cnt = r_rc_q;
                endcase
                n_state = S_FIN;
            end
            S_B1: begin
                n_cur   = ({1'b0, r_bump} + w_amask) & ~w_amask;
                n_state = S_B2;
            end
            S_B2: begin
                n_next  = {1'b0, r_cur} + 50'(r_bytes);
                n_state = S_B3;
            end
            S_B3: begin
                if (r_next > {2'b00, r_end}) begin
                    n_state = S_FIN;
                end else begin
                    n_bump     = r_next[47:0];
                    n_ok       = 1'b1;
                    n_addr     = r_cur[47:0];
                    n_lo_m     = MW'(({1'b0, r_cur} + 50'(PMASK)) >> LOG);
                    n_hi_m     = MW'(r_next >> LOG);
                    n_cur_ok   = (r_cur[LOG-1:0] == '0) && (r_cur >= 49'(RAM_BASE))
                                 && (64'(r_cur) < LIM);
                    n_cur_slot = SW'(64'(r_cur >> LOG) - CEILQ);
                    n_state    = S_B4;
                end
            end
            S_B4: begin
                n_s     = f_clip(r_lo_m);
                n_hi    = f_clip(r_hi_m);
                n_state = S_CRD;
            end
            S_CRD: begin
                if (r_s < r_hi) begin
                    w_rc_re = 1'b1;
                    n_state = S_CWR;
                end else if (r_cur_ok) begin
                    w_rc_re    = 1'b1;
                    w_rc_raddr = r_cur_slot;
                    n_state    = S_CNT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_CWR: begin
                if (r_rc_q == 16'd0) begin
                    w_rc_we    = 1'b1;
                    w_rc_wdata = 16'd1;
                    n_owned    = w_own_inc;
                end
                n_s     = r_s + SW1'(1);
                n_state = S_CRD;
            end
            S_CNT: begin
                n_cnt   = r_rc_q;
                n_state = S_FIN;
            end
            S_FIN: begin
                n_span  = (w_pcur < {1'b0, r_end})
                          ? SPW'(({1'b0, r_end} - w_pcur) >> LOG) : '0;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // Region registers are written only while no job is in flight
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_START: begin
                    n_start = i_cfg_data;
                    n_bump  = 48'((49'(i_cfg_data) + START_ALIGN - 49'd1)
                                  & ~(START_ALIGN - 49'd1));
                end
                REG_END: n_end = i_cfg_data;
                default: n_end = r_end;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_s     <= '0;
            r_top   <= '0;
            r_owned <= 16'd0;
            r_bump  <= RPA_BUMP_RST;
            r_start <= RPA_START_RST;
            r_end   <= RPA_END_RST;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s     <= n_s;
            r_top   <= n_top;
            r_owned <= n_owned;
            r_bump  <= n_bump;
            r_start <= n_start;
            r_end   <= n_end;
            r_o_vld <= (r_state == S_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;       r_hi <= n_hi;       r_lg <= n_lg;     r_bytes <= n_bytes;
        r_cur <= n_cur;       r_next <= n_next;   r_lo_m <= n_lo_m; r_hi_m <= n_hi_m;
        r_cur_ok <= n_cur_ok; r_cur_slot <= n_cur_slot;
        r_ok <= n_ok;         r_addr <= n_addr;   r_cnt <= n_cnt;   r_span <= n_span;
        if (r_state == S_OUT) begin
            r_o_ok    <= r_ok;
            r_o_addr  <= r_addr;
            r_o_cnt   <= r_cnt;
            r_o_used  <= r_owned;
            r_o_avail <= (w_sum[48:32] != '0) ? 32'hFFFF_FFFF : w_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rc_we) begin
            r_rc_mem[w_rc_waddr] <= w_rc_wdata;
        end
        if (w_rc_re) begin
            r_rc_q <= r_rc_mem[w_rc_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_st_we) begin
            r_st_mem[w_st_waddr] <= w_st_wdata;
        end
        if (w_st_re) begin
            r_st_q <= r_st_mem[w_st_raddr];
        end
    end

    assign o_res_valid       = r_o_vld;
    assign o_success         = r_o_ok;
    assign o_result_address  = r_o_addr;
    assign o_ref_count       = r_o_cnt;
    assign o_used_pages      = r_o_used;
    assign o_available_pages = r_o_avail;

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= SW1'(PAGE_COUNT)) else $error("free stack depth out of range");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |=> !r_o_vld) else $error("result strobe held two cycles");

    a_no_result_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !r_o_vld) else $error("result during table clear");

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != S_IDLE)) else $error("job popped but not started");

endmodule
